### design/isb_pkg.sv
// Shared types and codes for the interval signal binning block.
// Used by isb_ctrl, isb_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package isb_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_OPEN     = 2'd0;
    localparam logic [1:0] KIND_INTERVAL = 2'd1;
    localparam logic [1:0] KIND_READ     = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OPENED  = 3'd0;
    localparam logic [2:0] ST_ADDED   = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_RESEND  = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_BAD     = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_CLEAR,
        S_CLASSIFY,
        S_SPAN,
        S_ADD,
        S_READ,
        S_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted input beat
        logic open_peak;   // load peak registers, arm the clearing sweep
        logic clear_step;  // zero one bin
        logic classify;    // compare interval with peak
        logic span;        // work out first bin and bin count
        logic add_read;    // read one bin for read-modify-write
        logic read_bin;    // read the requested bin
        logic result;      // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic left_zero;   // sweep / add counter exhausted
        logic out_busy;    // output register holds a beat not yet taken
    } t_stat;

endpackage

### design/isb_ctrl.sv
// Controller for the interval signal binning block: sequences one item at a time.
// Depends on isb_pkg.
`timescale 1ns / 1ps

module isb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    input  isb_pkg::t_stat    i_stat,
    output isb_pkg::t_cmd     o_cmd,
    output logic              o_stall
);

    isb_pkg::t_state r_state;
    isb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            isb_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_kind)
                        isb_pkg::KIND_OPEN:     n_state = isb_pkg::S_OPEN;
                        isb_pkg::KIND_INTERVAL: n_state = isb_pkg::S_CLASSIFY;
                        isb_pkg::KIND_READ:     n_state = isb_pkg::S_READ;
                        default:                n_state = isb_pkg::S_RESULT;
                    endcase
                end
            end
            isb_pkg::S_OPEN:     n_state = isb_pkg::S_CLEAR;
            isb_pkg::S_CLEAR: begin
                if (i_stat.left_zero) begin
                    n_state = isb_pkg::S_RESULT;
                end
            end
            isb_pkg::S_CLASSIFY: n_state = isb_pkg::S_SPAN;
            isb_pkg::S_SPAN:     n_state = isb_pkg::S_ADD;
            isb_pkg::S_ADD: begin
                // last write-back lands on the edge that leaves this state
                if (i_stat.left_zero) begin
                    n_state = isb_pkg::S_RESULT;
                end
            end
            isb_pkg::S_READ:     n_state = isb_pkg::S_RESULT;
            isb_pkg::S_RESULT: begin
                if (!i_stat.out_busy) begin
                    n_state = isb_pkg::S_IDLE;
                end
            end
            default:             n_state = isb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            isb_pkg::S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            isb_pkg::S_OPEN:     o_cmd.open_peak  = 1'b1;
            isb_pkg::S_CLEAR:    o_cmd.clear_step = !i_stat.left_zero;
            isb_pkg::S_CLASSIFY: o_cmd.classify   = 1'b1;
            isb_pkg::S_SPAN:     o_cmd.span       = 1'b1;
            isb_pkg::S_ADD:      o_cmd.add_read   = !i_stat.left_zero;
            isb_pkg::S_READ:     o_cmd.read_bin   = 1'b1;
            isb_pkg::S_RESULT:   o_cmd.result     = !i_stat.out_busy;
            default:             o_cmd            = '0;
        endcase
    end

endmodule

### design/isb_datapath.sv
// Datapath for the interval signal binning block: peak registers, bin memory,
// saturating read-modify-write and the output register. Depends on isb_pkg.
`timescale 1ns / 1ps

module isb_datapath #(
    parameter int MAX_BINS  = 1024,
    parameter int SUM_WIDTH = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isb_pkg::t_cmd       i_cmd,
    output isb_pkg::t_stat      o_stat,
    input  logic [31:0]         i_start_position,
    input  logic [31:0]         i_end_position,
    input  logic [10:0]         i_peak_length,
    input  logic signed [31:0]  i_interval_value,
    input  logic [9:0]          i_bin_index,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic signed [39:0]  o_bin_value,
    output logic [9:0]          o_add_offset,
    output logic [10:0]         o_add_count
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam logic signed [SUM_WIDTH-1:0] SumMax = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SumMin = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // captured beat
    logic [31:0]            r_s;
    logic [31:0]            r_e;
    logic [10:0]            r_len;
    logic signed [31:0]     r_val;
    logic [9:0]             r_idx;

    // peak state
    logic [31:0]            r_peak_begin;
    logic [CW-1:0]          r_peak_size;
    logic [32:0]            r_peak_end;

    // per-item working registers
    logic [2:0]             r_status;
    logic [31:0]            r_lo;
    logic [31:0]            r_hi;
    logic [9:0]             r_add_offset;
    logic [10:0]            r_add_count;
    logic [AW-1:0]          r_addr;
    logic [CW-1:0]          r_left;
    logic                   r_wb_valid;
    logic [AW-1:0]          r_wb_addr;

    // bin memory
    logic signed [SUM_WIDTH-1:0] r_bins [MAX_BINS];
    logic signed [SUM_WIDTH-1:0] r_rd_data;

    // output register
    logic                   r_out_valid;
    logic [2:0]             r_out_status;
    logic signed [39:0]     r_out_bin_value;
    logic [9:0]             r_out_add_offset;
    logic [10:0]            r_out_add_count;

    logic [31:0]            w_size_sat;
    logic                   w_dropped;
    logic                   w_before_end;
    logic [31:0]            w_lo;
    logic [31:0]            w_hi;
    logic                   w_nonempty;
    logic [31:0]            w_first;
    logic [31:0]            w_cnt;
    logic [31:0]            w_idx_ext;
    logic                   w_idx_ok;
    logic signed [SUM_WIDTH:0]   w_sum;
    logic signed [SUM_WIDTH-1:0] w_sat;
    logic signed [63:0]     w_rd_ext;
    logic                   w_mem_we;
    logic [AW-1:0]          w_mem_waddr;
    logic signed [SUM_WIDTH-1:0] w_mem_wdata;
    logic                   w_mem_re;
    logic [AW-1:0]          w_mem_raddr;

    // open: clamp the length to the memory depth
    assign w_size_sat = (32'(r_len) > 32'(MAX_BINS)) ? 32'(MAX_BINS) : 32'(r_len);

    // classify
    assign w_dropped    = r_e < r_peak_begin;
    assign w_before_end = {1'b0, r_s} < r_peak_end;
    assign w_lo         = (r_s > r_peak_begin) ? r_s : r_peak_begin;
    // when the peak end is below the interval end it fits in 32 bits
    assign w_hi         = ({1'b0, r_e} < r_peak_end) ? r_e : r_peak_end[31:0];

    // span
    assign w_nonempty = r_hi > r_lo;
    assign w_first    = r_lo - r_peak_begin;
    assign w_cnt      = r_hi - r_lo;

    // bin read
    assign w_idx_ext = 32'(r_idx);
    assign w_idx_ok  = w_idx_ext < 32'(r_peak_size);

    // saturating accumulate
    assign w_sum = (SUM_WIDTH+1)'(r_rd_data) + (SUM_WIDTH+1)'(r_val);
    always_comb begin
        if (w_sum[SUM_WIDTH] != w_sum[SUM_WIDTH-1]) begin
            w_sat = w_sum[SUM_WIDTH] ? SumMin : SumMax;
        end else begin
            w_sat = w_sum[SUM_WIDTH-1:0];
        end
    end

    assign w_rd_ext = 64'(r_rd_data);

    // one write port: clearing sweep or write-back, never both
    assign w_mem_we    = i_cmd.clear_step || r_wb_valid;
    assign w_mem_waddr = i_cmd.clear_step ? r_addr : r_wb_addr;
    assign w_mem_wdata = i_cmd.clear_step ? '0 : w_sat;
    assign w_mem_re    = i_cmd.add_read || (i_cmd.read_bin && w_idx_ok);
    assign w_mem_raddr = i_cmd.add_read ? r_addr : w_idx_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_bins[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_data <= r_bins[w_mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_s   <= i_start_position;
            r_e   <= i_end_position;
            r_len <= i_peak_length;
            r_val <= i_interval_value;
            r_idx <= i_bin_index;
        end
        if (i_cmd.classify) begin
            r_lo <= w_lo;
            r_hi <= w_hi;
        end
        if (r_wb_valid || i_cmd.add_read) begin
            r_wb_addr <= r_addr;
        end
        if (i_cmd.result) begin
            r_out_status     <= r_status;
            r_out_bin_value  <= (r_status == isb_pkg::ST_READ) ? w_rd_ext[39:0] : '0;
            r_out_add_offset <= r_add_offset;
            r_out_add_count  <= r_add_count;
        end
    end

    // control and peak state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_begin <= '0;
            r_peak_size  <= '0;
            r_peak_end   <= '0;
            r_status     <= isb_pkg::ST_BAD;
            r_add_offset <= '0;
            r_add_count  <= '0;
            r_addr       <= '0;
            r_left       <= '0;
            r_wb_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_wb_valid <= i_cmd.add_read;

            if (i_cmd.capture) begin
                r_status     <= isb_pkg::ST_BAD;
                r_add_offset <= '0;
                r_add_count  <= '0;
            end

            if (i_cmd.open_peak) begin
                r_peak_begin <= r_s;
                r_peak_size  <= w_size_sat[CW-1:0];
                r_peak_end   <= {1'b0, r_s} + {1'b0, w_size_sat};
                r_status     <= isb_pkg::ST_OPENED;
                // bins past the new size are never read, so only these are cleared
                r_addr       <= '0;
                r_left       <= w_size_sat[CW-1:0];
            end

            if (i_cmd.classify) begin
                if (w_dropped) begin
                    r_status <= isb_pkg::ST_DROPPED;
                end else if (w_before_end) begin
                    r_status <= isb_pkg::ST_ADDED;
                end else begin
                    r_status <= isb_pkg::ST_RESEND;
                end
            end

            if (i_cmd.span) begin
                if ((r_status == isb_pkg::ST_ADDED) && w_nonempty) begin
                    r_addr       <= w_first[AW-1:0];
                    r_left       <= w_cnt[CW-1:0];
                    r_add_offset <= w_first[9:0];
                    r_add_count  <= w_cnt[10:0];
                end else begin
                    r_left <= '0;
                end
            end

            if (i_cmd.clear_step || i_cmd.add_read) begin
                r_addr <= r_addr + 1'b1;
                r_left <= r_left - 1'b1;
            end

            if (i_cmd.read_bin && w_idx_ok) begin
                r_status <= isb_pkg::ST_READ;
            end

            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.out_busy  = r_out_valid && i_stall;

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_bin_value  = r_out_bin_value;
    assign o_add_offset = r_out_add_offset;
    assign o_add_count  = r_out_add_count;

    // clearing sweep and accumulate never share the write port
    a_wport_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wb_valid && i_cmd.clear_step))
        else $error("write-back collides with clearing sweep");

    // sweeps stay inside the open peak
    a_addr_in_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clear_step || i_cmd.add_read) |-> (32'(r_addr) < 32'(r_peak_size)))
        else $error("bin address beyond peak size");

    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_peak_size)
        else $error("remaining bin count exceeds peak size");

    // a result is only reported once the last bin is written back
    a_result_after_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.result |-> !r_wb_valid)
        else $error("result loaded with a write-back pending");

endmodule

### design/interval_signal_binning.sv
// Interval signal binning: one open peak region with a saturating accumulator per bin,
// fed by open, interval and read items. One item is in flight at a time; the bin memory,
// with one read port and one write port, handles one bin per cycle. An open item clears
// the bins of its peak length (capped at MAX_BINS) one per cycle; an interval item goes
// through compare, span, one read-modify-write per bin and a final write-back drain; a
// read item reads the requested bin if it lies inside the peak, and an unused kind goes
// straight to its result. The result sits in an output register, so the next item is
// taken while the previous beat waits; if that beat is still held by the receiver when
// the next result is ready, the controller waits in its result state and the input
// stays stalled.
// Depends on isb_pkg, isb_ctrl and isb_datapath.
`timescale 1ns / 1ps

module interval_signal_binning #(
    parameter int MAX_BINS  = 1024,
    parameter int SUM_WIDTH = 40
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_kind,
    input  logic [31:0]         i_start_position,
    input  logic [31:0]         i_end_position,
    input  logic [10:0]         i_peak_length,
    input  logic signed [31:0]  i_interval_value,
    input  logic [9:0]          i_bin_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic signed [39:0]  o_bin_value,
    output logic [9:0]          o_add_offset,
    output logic [10:0]         o_add_count
);

    isb_pkg::t_cmd  w_cmd;
    isb_pkg::t_stat w_stat;

    isb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    isb_datapath #(
        .MAX_BINS  (MAX_BINS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_start_position (i_start_position),
        .i_end_position   (i_end_position),
        .i_peak_length    (i_peak_length),
        .i_interval_value (i_interval_value),
        .i_bin_index      (i_bin_index),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_bin_value      (o_bin_value),
        .o_add_offset     (o_add_offset),
        .o_add_count      (o_add_count)
    );

endmodule
